/* rtl/mbsrm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsrm_pkg
// Shared types and constants of the Modbus server register map.
// ----------------------------------------------------------------------------
package mbsrm_pkg;

  localparam int NUM_COILS      = 2048;
  localparam int NUM_DISCRETE   = 2048;
  localparam int NUM_HOLDING    = 256;
  localparam int NUM_INPUT_REGS = 256;
  localparam int STAGE_DEPTH    = 256;

  localparam int COIL_AW  = (NUM_COILS > 1)      ? $clog2(NUM_COILS)      : 1;
  localparam int DISC_AW  = (NUM_DISCRETE > 1)   ? $clog2(NUM_DISCRETE)   : 1;
  localparam int HOLD_AW  = (NUM_HOLDING > 1)    ? $clog2(NUM_HOLDING)    : 1;
  localparam int INREG_AW = (NUM_INPUT_REGS > 1) ? $clog2(NUM_INPUT_REGS) : 1;
  localparam int STG_AW   = $clog2(STAGE_DEPTH);

  localparam int CLR_N01 = (NUM_COILS > NUM_DISCRETE) ? NUM_COILS : NUM_DISCRETE;
  localparam int CLR_N23 = (NUM_HOLDING > NUM_INPUT_REGS) ? NUM_HOLDING : NUM_INPUT_REGS;
  localparam int CLR_N   = (CLR_N01 > CLR_N23) ? CLR_N01 : CLR_N23;
  localparam int CLR_AW  = (CLR_N > 1) ? $clog2(CLR_N) : 1;

  localparam logic [15:0] MAX_BITS  = 16'd2000;
  localparam logic [15:0] MAX_WORDS = 16'd125;
  localparam logic [15:0] COIL_ON   = 16'hFF00;
  localparam logic [15:0] COIL_OFF  = 16'h0000;

  localparam logic [7:0] FC_RD_COILS = 8'd1;
  localparam logic [7:0] FC_RD_DISC  = 8'd2;
  localparam logic [7:0] FC_RD_HOLD  = 8'd3;
  localparam logic [7:0] FC_RD_INREG = 8'd4;
  localparam logic [7:0] FC_WR_COIL  = 8'd5;
  localparam logic [7:0] FC_WR_REG   = 8'd6;
  localparam logic [7:0] FC_WR_COILS = 8'd15;
  localparam logic [7:0] FC_WR_REGS  = 8'd16;

  typedef enum logic [1:0] {
    KIND_HEADER, KIND_PAYLOAD, KIND_SET_DI, KIND_SET_IR
  } kind_t;

  typedef enum logic [1:0] {
    EXC_NONE, EXC_FUNCTION, EXC_ADDRESS, EXC_VALUE
  } exc_t;

  typedef enum logic [1:0] {
    OP_NOP, OP_SERVE, OP_SET_DI, OP_SET_IR
  } op_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_EXC, ST_ECHO,
    ST_RB_HDR, ST_RB_REQ, ST_RB_ACC, ST_RB_PUSH,
    ST_RW_HDR, ST_RW_REQ, ST_RW_HI, ST_RW_LO,
    ST_WC_REQ, ST_WC_WR, ST_WR_A, ST_WR_B, ST_WR_C
  } bk_state_t;

  typedef struct packed {
    logic              stage;
    logic [STG_AW-1:0] stage_idx;
    logic [7:0]        stage_byte;
    op_t               op;
    logic [7:0]        fc;
    logic [15:0]       addr;
    logic [15:0]       qv;
    logic [7:0]        pc;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } bk_status_t;

endpackage

/* rtl/mbsrm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsrm_in_if / mbsrm_out_if
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface mbsrm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  fcode;
  logic [15:0] start_address;
  logic [15:0] qty_value;
  logic [7:0]  payload_count;
  logic [7:0]  payload_byte;

  modport source (output valid, kind, fcode, start_address, qty_value,
                  payload_count, payload_byte, input ready);
  modport sink (input valid, kind, fcode, start_address, qty_value,
                payload_count, payload_byte, output ready);
endinterface

interface mbsrm_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  echo_function;
  logic [1:0]  exception_code;
  logic [63:0] payload_beat;
  logic [3:0]  beat_bytes;
  logic        last_beat;

  modport source (output valid, echo_function, exception_code, payload_beat, beat_bytes,
                  last_beat, input ready);
  modport sink (input valid, echo_function, exception_code, payload_beat, beat_bytes,
                last_beat, output ready);
endinterface

/* rtl/mbsrm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsrm_front
// Accepts items, tracks the pending write-multiple header and turns items
// into commands for the back end.
// ----------------------------------------------------------------------------
module mbsrm_front (
  input  logic                   clk,
  input  logic                   rst_n,
  mbsrm_in_if.sink               in_ch,
  input  mbsrm_pkg::bk_status_t  bk_status,
  input  logic                   q_full,
  output logic                   q_push,
  output mbsrm_pkg::cmd_t        q_cmd
);
  import mbsrm_pkg::*;

  logic        pend_valid_r, pend_valid_nxt;
  logic [7:0]  pend_fc_r, pend_fc_nxt;
  logic [15:0] pend_addr_r, pend_addr_nxt;
  logic [15:0] pend_qv_r, pend_qv_nxt;
  logic [7:0]  pend_pc_r, pend_pc_nxt;
  logic [7:0]  staged_cnt_r, staged_cnt_nxt;
  logic        accept;
  logic [7:0]  cnt_inc;

  assign in_ch.ready = !q_full && !bk_status.clearing;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cnt_inc     = staged_cnt_r + 8'd1;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_fc_nxt    = pend_fc_r;
    pend_addr_nxt  = pend_addr_r;
    pend_qv_nxt    = pend_qv_r;
    pend_pc_nxt    = pend_pc_r;
    staged_cnt_nxt = staged_cnt_r;
    q_push         = 1'b0;
    q_cmd.stage      = 1'b0;
    q_cmd.stage_idx  = staged_cnt_r[STG_AW-1:0];
    q_cmd.stage_byte = in_ch.payload_byte;
    q_cmd.op         = OP_NOP;
    q_cmd.fc         = in_ch.fcode;
    q_cmd.addr       = in_ch.start_address;
    q_cmd.qv         = in_ch.qty_value;
    q_cmd.pc         = in_ch.payload_count;
    if (accept) begin
      case (kind_t'(in_ch.kind))
        KIND_HEADER: begin
          pend_valid_nxt = 1'b0;
          staged_cnt_nxt = 8'd0;
          if ((in_ch.fcode == FC_WR_COILS || in_ch.fcode == FC_WR_REGS)
              && in_ch.payload_count != 8'd0) begin
            pend_valid_nxt = 1'b1;
            pend_fc_nxt    = in_ch.fcode;
            pend_addr_nxt  = in_ch.start_address;
            pend_qv_nxt    = in_ch.qty_value;
            pend_pc_nxt    = in_ch.payload_count;
          end else begin
            q_push   = 1'b1;
            q_cmd.op = OP_SERVE;
          end
        end
        KIND_PAYLOAD: begin
          if (pend_valid_r) begin
            q_cmd.stage    = (32'(staged_cnt_r) < STAGE_DEPTH);
            q_cmd.fc       = pend_fc_r;
            q_cmd.addr     = pend_addr_r;
            q_cmd.qv       = pend_qv_r;
            q_cmd.pc       = pend_pc_r;
            staged_cnt_nxt = cnt_inc;
            if (cnt_inc == pend_pc_r) begin
              q_cmd.op       = OP_SERVE;
              pend_valid_nxt = 1'b0;
              staged_cnt_nxt = 8'd0;
            end
            q_push = q_cmd.stage || (q_cmd.op == OP_SERVE);
          end
        end
        KIND_SET_DI: begin
          q_push   = 1'b1;
          q_cmd.op = OP_SET_DI;
        end
        KIND_SET_IR: begin
          q_push   = 1'b1;
          q_cmd.op = OP_SET_IR;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      staged_cnt_r <= 8'd0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      staged_cnt_r <= staged_cnt_nxt;
    end
    pend_fc_r   <= pend_fc_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_qv_r   <= pend_qv_nxt;
    pend_pc_r   <= pend_pc_nxt;
  end

endmodule

/* rtl/mbsrm_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsrm_fifo
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
module mbsrm_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mbsrm_pkg::cmd_t push_cmd,
  input  logic            pop,
  output mbsrm_pkg::cmd_t pop_cmd,
  output logic            full,
  output logic            empty
);
  import mbsrm_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign pop_cmd = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) entry_r[wr_ptr_r] <= push_cmd;
  end

endmodule

/* rtl/mbsrm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsrm_back
// Holds the four tables and the staging buffer, runs the checks, walks the
// tables and packs response bytes into beats.
// ----------------------------------------------------------------------------
module mbsrm_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  mbsrm_pkg::cmd_t        q_cmd,
  output logic                   q_pop,
  output mbsrm_pkg::bk_status_t  bk_status,
  mbsrm_out_if.source            out_ch
);
  import mbsrm_pkg::*;

  function automatic logic range_ok(logic [15:0] a, logic [15:0] q, int size);
    return (32'(a) < size) && (32'(a) + 32'(q) <= size);
  endfunction

  logic coil_mem  [NUM_COILS];
  logic disc_mem  [NUM_DISCRETE];
  logic [15:0] hold_mem  [NUM_HOLDING];
  logic [15:0] inreg_mem [NUM_INPUT_REGS];
  logic [7:0]  stg_mem   [STAGE_DEPTH];

  bk_state_t   state_r, state_nxt;
  cmd_t        cmd_r, cmd_nxt;
  exc_t        exc_r, exc_nxt;
  logic [10:0] cnt_r, cnt_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [CLR_AW-1:0] clr_r, clr_nxt;
  logic [63:0] pack_r, pack_nxt;
  logic [2:0]  pcnt_r, pcnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_fc_r, out_fc_nxt;
  exc_t        out_exc_r, out_exc_nxt;
  logic [63:0] out_beat_r, out_beat_nxt;
  logic [3:0]  out_bytes_r, out_bytes_nxt;
  logic        out_last_r, out_last_nxt;

  logic        coil_we, coil_wd, coil_q;
  logic [COIL_AW-1:0] coil_wa;
  logic        disc_we, disc_wd, disc_q;
  logic [DISC_AW-1:0] disc_wa;
  logic        hold_we;
  logic [15:0] hold_wd, hold_q;
  logic [HOLD_AW-1:0] hold_wa;
  logic        inreg_we;
  logic [15:0] inreg_wd, inreg_q;
  logic [INREG_AW-1:0] inreg_wa;
  logic        stg_we;
  logic [STG_AW-1:0] stg_ra;
  logic [7:0]  stg_q;

  logic [16:0] tab_addr;
  logic [11:0] stg_idx2;
  logic [15:0] qv_m1;
  logic [15:0] word;
  logic        bv, bl, btake, out_free;
  logic [7:0]  bd;

  assign tab_addr = {1'b0, cmd_r.addr} + 17'(cnt_r);
  assign stg_idx2 = {cnt_r, 1'b0};
  assign qv_m1    = cmd_r.qv - 16'd1;
  assign word     = (cmd_r.fc == FC_RD_HOLD) ? hold_q : inreg_q;
  assign out_free = !out_valid_r || out_ch.ready;
  assign btake    = bv && out_free;
  assign bk_status.clearing = (state_r == ST_CLEAR);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    exc_nxt   = exc_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    hi_nxt    = hi_r;
    clr_nxt   = clr_r;
    q_pop     = 1'b0;
    bv = 1'b0;
    bd = 8'd0;
    bl = 1'b0;
    coil_we  = 1'b0;
    coil_wa  = tab_addr[COIL_AW-1:0];
    coil_wd  = 1'b0;
    disc_we  = 1'b0;
    disc_wa  = q_cmd.addr[DISC_AW-1:0];
    disc_wd  = (q_cmd.qv != 16'd0);
    hold_we  = 1'b0;
    hold_wa  = tab_addr[HOLD_AW-1:0];
    hold_wd  = cmd_r.qv;
    inreg_we = 1'b0;
    inreg_wa = q_cmd.addr[INREG_AW-1:0];
    inreg_wd = q_cmd.qv;
    stg_we   = 1'b0;
    stg_ra   = '0;
    case (state_r)
      ST_CLEAR: begin
        coil_wa  = clr_r[COIL_AW-1:0];
        disc_wa  = clr_r[DISC_AW-1:0];
        hold_wa  = clr_r[HOLD_AW-1:0];
        inreg_wa = clr_r[INREG_AW-1:0];
        disc_wd  = 1'b0;
        hold_wd  = 16'd0;
        inreg_wd = 16'd0;
        coil_we  = (32'(clr_r) < NUM_COILS);
        disc_we  = (32'(clr_r) < NUM_DISCRETE);
        hold_we  = (32'(clr_r) < NUM_HOLDING);
        inreg_we = (32'(clr_r) < NUM_INPUT_REGS);
        clr_nxt  = clr_r + 1'b1;
        if (32'(clr_r) == CLR_N - 1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          cnt_nxt = 11'd0;
          stg_we  = q_cmd.stage;
          case (q_cmd.op)
            OP_SERVE:  state_nxt = ST_EXEC;
            OP_SET_DI: disc_we = (32'(q_cmd.addr) < NUM_DISCRETE);
            OP_SET_IR: inreg_we = (32'(q_cmd.addr) < NUM_INPUT_REGS);
            default: ;
          endcase
        end
      end
      ST_EXEC: begin
        state_nxt = ST_EXC;
        case (cmd_r.fc)
          FC_RD_COILS, FC_RD_DISC: begin
            if (!range_ok(cmd_r.addr, cmd_r.qv,
                          (cmd_r.fc == FC_RD_COILS) ? NUM_COILS : NUM_DISCRETE))
              exc_nxt = EXC_ADDRESS;
            else if (cmd_r.qv == 16'd0 || cmd_r.qv > MAX_BITS) exc_nxt = EXC_VALUE;
            else state_nxt = ST_RB_HDR;
          end
          FC_RD_HOLD, FC_RD_INREG: begin
            if (!range_ok(cmd_r.addr, cmd_r.qv,
                          (cmd_r.fc == FC_RD_HOLD) ? NUM_HOLDING : NUM_INPUT_REGS))
              exc_nxt = EXC_ADDRESS;
            else if (cmd_r.qv == 16'd0 || cmd_r.qv > MAX_WORDS) exc_nxt = EXC_VALUE;
            else state_nxt = ST_RW_HDR;
          end
          FC_WR_COIL: begin
            if (!range_ok(cmd_r.addr, 16'd1, NUM_COILS)) exc_nxt = EXC_ADDRESS;
            else if (cmd_r.qv != COIL_ON && cmd_r.qv != COIL_OFF) exc_nxt = EXC_VALUE;
            else begin
              coil_we   = 1'b1;
              coil_wd   = (cmd_r.qv == COIL_ON);
              state_nxt = ST_ECHO;
            end
          end
          FC_WR_REG: begin
            if (!range_ok(cmd_r.addr, 16'd1, NUM_HOLDING)) exc_nxt = EXC_ADDRESS;
            else begin
              hold_we   = 1'b1;
              state_nxt = ST_ECHO;
            end
          end
          FC_WR_COILS: begin
            if (!range_ok(cmd_r.addr, cmd_r.qv, NUM_COILS)) exc_nxt = EXC_ADDRESS;
            else if (cmd_r.qv == 16'd0 || cmd_r.qv > MAX_BITS) exc_nxt = EXC_VALUE;
            else if ({8'd0, cmd_r.pc} != ((cmd_r.qv + 16'd7) >> 3)
                     || 32'(cmd_r.pc) > STAGE_DEPTH) exc_nxt = EXC_VALUE;
            else state_nxt = ST_WC_REQ;
          end
          FC_WR_REGS: begin
            if (!range_ok(cmd_r.addr, cmd_r.qv, NUM_HOLDING)) exc_nxt = EXC_ADDRESS;
            else if (cmd_r.qv == 16'd0 || cmd_r.qv > MAX_WORDS) exc_nxt = EXC_VALUE;
            else if ({8'd0, cmd_r.pc} != {cmd_r.qv[14:0], 1'b0}
                     || 32'(cmd_r.pc) > STAGE_DEPTH) exc_nxt = EXC_VALUE;
            else state_nxt = ST_WR_A;
          end
          default: exc_nxt = EXC_FUNCTION;
        endcase
      end
      ST_EXC: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_ECHO: begin
        bv = 1'b1;
        case (cnt_r[1:0])
          2'd0:    bd = cmd_r.addr[15:8];
          2'd1:    bd = cmd_r.addr[7:0];
          2'd2:    bd = cmd_r.qv[15:8];
          default: bd = cmd_r.qv[7:0];
        endcase
        bl = (cnt_r[1:0] == 2'd3);
        if (btake) begin
          cnt_nxt = cnt_r + 11'd1;
          if (bl) state_nxt = ST_IDLE;
        end
      end
      ST_RB_HDR: begin
        bv = 1'b1;
        bd = 8'((cmd_r.qv + 16'd7) >> 3);
        if (btake) begin
          acc_nxt   = 8'd0;
          state_nxt = ST_RB_REQ;
        end
      end
      ST_RB_REQ: state_nxt = ST_RB_ACC;
      ST_RB_ACC: begin
        acc_nxt = acc_r | (8'((cmd_r.fc == FC_RD_COILS) ? coil_q : disc_q) << cnt_r[2:0]);
        cnt_nxt = cnt_r + 11'd1;
        if (cnt_r[2:0] == 3'd7 || {5'd0, cnt_r} == qv_m1) state_nxt = ST_RB_PUSH;
        else state_nxt = ST_RB_REQ;
      end
      ST_RB_PUSH: begin
        bv = 1'b1;
        bd = acc_r;
        bl = ({5'd0, cnt_r} == cmd_r.qv);
        if (btake) begin
          acc_nxt   = 8'd0;
          state_nxt = bl ? ST_IDLE : ST_RB_REQ;
        end
      end
      ST_RW_HDR: begin
        bv = 1'b1;
        bd = {cmd_r.qv[6:0], 1'b0};
        if (btake) state_nxt = ST_RW_REQ;
      end
      ST_RW_REQ: state_nxt = ST_RW_HI;
      ST_RW_HI: begin
        bv = 1'b1;
        bd = word[15:8];
        if (btake) state_nxt = ST_RW_LO;
      end
      ST_RW_LO: begin
        bv = 1'b1;
        bd = word[7:0];
        bl = ({5'd0, cnt_r} == qv_m1);
        if (btake) begin
          cnt_nxt   = cnt_r + 11'd1;
          state_nxt = bl ? ST_IDLE : ST_RW_REQ;
        end
      end
      ST_WC_REQ: begin
        stg_ra    = cnt_r[STG_AW+2:3];
        state_nxt = ST_WC_WR;
      end
      ST_WC_WR: begin
        coil_we = 1'b1;
        coil_wd = stg_q[cnt_r[2:0]];
        if ({5'd0, cnt_r} == qv_m1) begin
          cnt_nxt   = 11'd0;
          state_nxt = ST_ECHO;
        end else begin
          cnt_nxt   = cnt_r + 11'd1;
          state_nxt = ST_WC_REQ;
        end
      end
      ST_WR_A: begin
        stg_ra    = stg_idx2[STG_AW-1:0];
        state_nxt = ST_WR_B;
      end
      ST_WR_B: begin
        hi_nxt    = stg_q;
        stg_ra    = stg_idx2[STG_AW-1:0] | STG_AW'(1);
        state_nxt = ST_WR_C;
      end
      ST_WR_C: begin
        hold_we = 1'b1;
        hold_wd = {hi_r, stg_q};
        if ({5'd0, cnt_r} == qv_m1) begin
          cnt_nxt   = 11'd0;
          state_nxt = ST_ECHO;
        end else begin
          cnt_nxt   = cnt_r + 11'd1;
          state_nxt = ST_WR_A;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // beat packer and output register
  always_comb begin
    pack_nxt      = pack_r;
    pcnt_nxt      = pcnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_fc_nxt    = out_fc_r;
    out_exc_nxt   = out_exc_r;
    out_beat_nxt  = out_beat_r;
    out_bytes_nxt = out_bytes_r;
    out_last_nxt  = out_last_r;
    if (btake) begin
      pack_nxt[{pcnt_r, 3'b000} +: 8] = bd;
      if (pcnt_r == 3'd7 || bl) begin
        out_valid_nxt = 1'b1;
        out_fc_nxt    = cmd_r.fc;
        out_exc_nxt   = EXC_NONE;
        out_beat_nxt  = pack_nxt;
        out_bytes_nxt = {1'b0, pcnt_r} + 4'd1;
        out_last_nxt  = bl;
        pack_nxt      = 64'd0;
        pcnt_nxt      = 3'd0;
      end else begin
        pcnt_nxt = pcnt_r + 3'd1;
      end
    end
    if (state_r == ST_EXC && out_free) begin
      out_valid_nxt = 1'b1;
      out_fc_nxt    = cmd_r.fc;
      out_exc_nxt   = exc_r;
      out_beat_nxt  = 64'd0;
      out_bytes_nxt = 4'd0;
      out_last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      pack_r      <= 64'd0;
      pcnt_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pack_r      <= pack_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    exc_r       <= exc_nxt;
    cnt_r       <= cnt_nxt;
    acc_r       <= acc_nxt;
    hi_r        <= hi_nxt;
    out_fc_r    <= out_fc_nxt;
    out_exc_r   <= out_exc_nxt;
    out_beat_r  <= out_beat_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (coil_we) coil_mem[coil_wa] <= coil_wd;
    coil_q <= coil_mem[tab_addr[COIL_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (disc_we) disc_mem[disc_wa] <= disc_wd;
    disc_q <= disc_mem[tab_addr[DISC_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (hold_we) hold_mem[hold_wa] <= hold_wd;
    hold_q <= hold_mem[tab_addr[HOLD_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (inreg_we) inreg_mem[inreg_wa] <= inreg_wd;
    inreg_q <= inreg_mem[tab_addr[INREG_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (stg_we) stg_mem[q_cmd.stage_idx] <= q_cmd.stage_byte;
    stg_q <= stg_mem[stg_ra];
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.echo_function  = out_fc_r;
  assign out_ch.exception_code = out_exc_r;
  assign out_ch.payload_beat   = out_beat_r;
  assign out_ch.beat_bytes     = out_bytes_r;
  assign out_ch.last_beat      = out_last_r;

endmodule

/* rtl/modbus_server_register_map_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_server_register_map_unit
// Modbus server data model: coils, discrete inputs, holding and input
// registers, with request decode, checks and beat-packed responses.
// ----------------------------------------------------------------------------
// After reset the tables are cleared one entry per cycle; no item is taken
// until that pass ends. Items are accepted one per cycle while the two-entry
// command queue has room; the back end writes payload bytes and local updates
// from its idle state. Service is set by one read port per table: bit reads
// fetch and accumulate each bit, then push each response byte; word reads
// fetch each register and send both bytes; write-multiple coils read a staged
// byte per coil and registers two staged bytes per register; decode comes
// first and writes end in an echo; a stalled result port holds the back end.
module modbus_server_register_map_unit (
  input  logic        clk,
  input  logic        rst_n,
  mbsrm_in_if.sink    in_ch,
  mbsrm_out_if.source out_ch
);
  import mbsrm_pkg::*;

  bk_status_t bk_status;
  cmd_t       push_cmd, pop_cmd;
  logic       q_push, q_pop, q_full, q_empty;

  mbsrm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .bk_status (bk_status),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  mbsrm_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  mbsrm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .bk_status (bk_status),
    .out_ch    (out_ch)
  );

endmodule

/* rtl/mbsrm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsrm_checker
// Port-level checks on the response channel.
// ----------------------------------------------------------------------------
module mbsrm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_exception_code,
  input logic [63:0] out_payload_beat,
  input logic [3:0]  out_beat_bytes,
  input logic        out_last_beat
);
  import mbsrm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_beat)
      && $stable(out_beat_bytes) && $stable(out_exception_code) && $stable(out_last_beat))
    else $error("response item changed while stalled");

  a_exc_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exception_code != EXC_NONE |->
      out_beat_bytes == 4'd0 && out_last_beat && out_payload_beat == 64'd0)
    else $error("exception item carries payload");

  a_data_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exception_code == EXC_NONE |->
      out_beat_bytes != 4'd0 && out_beat_bytes <= 4'd8)
    else $error("data item byte count out of range");

  a_full_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_beat |-> out_beat_bytes == 4'd8
      && out_exception_code == EXC_NONE)
    else $error("non-final item not full");

endmodule

bind modbus_server_register_map_unit mbsrm_checker u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_exception_code (out_ch.exception_code),
  .out_payload_beat   (out_ch.payload_beat),
  .out_beat_bytes     (out_ch.beat_bytes),
  .out_last_beat      (out_ch.last_beat)
);

/* verif/mbsrm_tb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsrm_tb_if
// Testbench-side item types for the Modbus register map channels.
// ----------------------------------------------------------------------------
package mbsrm_tb_pkg;
  import mbsrm_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  fc;
    logic [15:0] addr;
    logic [15:0] qv;
    logic [7:0]  pc;
    logic [7:0]  pb;
  } req_item_t;

  typedef struct packed {
    logic [7:0]  fc;
    exc_t        exc;
    logic [63:0] beat;
    logic [3:0]  nbytes;
    logic        last;
  } rsp_item_t;
endpackage

/* verif/tb_modbus_server_register_map_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_server_register_map_unit
// Self-checking bench: directed and random Modbus requests, payload streams
// and local table updates; responses are predicted in-bench and compared beat
// by beat, with random idling on both channels and back-pressure phases.
// ----------------------------------------------------------------------------
module tb_modbus_server_register_map_unit;
  import mbsrm_pkg::*;
  import mbsrm_tb_pkg::*;

  localparam int LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  mbsrm_in_if  in_ch ();
  mbsrm_out_if out_ch ();

  modbus_server_register_map_unit DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .out_ch(out_ch));

  // predictor state
  logic        coils [NUM_COILS];
  logic        discs [NUM_DISCRETE];
  logic [15:0] holds [NUM_HOLDING];
  logic [15:0] iregs [NUM_INPUT_REGS];
  logic [7:0]  stage [STAGE_DEPTH];
  logic        pend_vld;
  logic [7:0]  pend_fc, pend_pc, stage_cnt;
  logic [15:0] pend_addr, pend_qv;

  req_item_t pending_reqs [$];
  rsp_item_t expected_rsps [$];
  logic [7:0] rbuf [$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;
  bit hold_sink = 0;
  int src_gap = 0, snk_gap = 0;

  task automatic add_req(input req_item_t it);
    pending_reqs.insert(pending_reqs.size(), it);
  endtask

  task automatic add_rsp(input rsp_item_t it);
    expected_rsps.insert(expected_rsps.size(), it);
  endtask

  task automatic report(input string msg);
    $display("MISMATCH @%0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic push_error(input logic [7:0] fc, input exc_t e);
    add_rsp('{fc, e, 64'd0, 4'd0, 1'b1});
  endtask

  task automatic push_bytes(input logic [7:0] fc);
    logic [63:0] b;
    int k;
    while (rbuf.size() > 0) begin
      b = '0;
      k = 0;
      while (k < 8 && rbuf.size() > 0) begin
        b[8*k +: 8] = rbuf.pop_front();
        k++;
      end
      add_rsp('{fc, EXC_NONE, b, 4'(k), rbuf.size() == 0});
    end
  endtask

  function automatic bit in_range(int a, int q, int size);
    return a < size && a + q <= size;
  endfunction

  task automatic echo4(input logic [7:0] fc, input logic [15:0] a, input logic [15:0] v);
    rbuf = {a[15:8], a[7:0], v[15:8], v[7:0]};
    push_bytes(fc);
  endtask

  task automatic serve_request(input logic [7:0] fc, input int a, input int q, input int pc);
    logic [7:0] byt;
    int nb;
    case (fc)
      FC_RD_COILS, FC_RD_DISC: begin
        int size;
        size = (fc == FC_RD_COILS) ? NUM_COILS : NUM_DISCRETE;
        if (!in_range(a, q, size)) push_error(fc, EXC_ADDRESS);
        else if (q == 0 || q > MAX_BITS) push_error(fc, EXC_VALUE);
        else begin
          nb = (q + 7) / 8;
          rbuf = {8'(nb)};
          for (int i = 0; i < nb; i++) begin
            byt = '0;
            for (int j = 0; j < 8 && 8*i+j < q; j++)
              byt[j] = (fc == FC_RD_COILS) ? coils[a+8*i+j] : discs[a+8*i+j];
            rbuf.insert(rbuf.size(), byt);
          end
          push_bytes(fc);
        end
      end
      FC_RD_HOLD, FC_RD_INREG: begin
        logic [15:0] w;
        if (!in_range(a, q, (fc == FC_RD_HOLD) ? NUM_HOLDING : NUM_INPUT_REGS))
          push_error(fc, EXC_ADDRESS);
        else if (q == 0 || q > MAX_WORDS) push_error(fc, EXC_VALUE);
        else begin
          rbuf = {8'(2*q)};
          for (int i = 0; i < q; i++) begin
            w = (fc == FC_RD_HOLD) ? holds[a+i] : iregs[a+i];
            rbuf.insert(rbuf.size(), w[15:8]);
            rbuf.insert(rbuf.size(), w[7:0]);
          end
          push_bytes(fc);
        end
      end
      FC_WR_COIL: begin
        if (!in_range(a, 1, NUM_COILS)) push_error(fc, EXC_ADDRESS);
        else if (q != COIL_ON && q != COIL_OFF) push_error(fc, EXC_VALUE);
        else begin
          coils[a] = (q == COIL_ON);
          echo4(fc, a, q);
        end
      end
      FC_WR_REG: begin
        if (!in_range(a, 1, NUM_HOLDING)) push_error(fc, EXC_ADDRESS);
        else begin
          holds[a] = q;
          echo4(fc, a, q);
        end
      end
      FC_WR_COILS: begin
        if (!in_range(a, q, NUM_COILS)) push_error(fc, EXC_ADDRESS);
        else if (q == 0 || q > MAX_BITS) push_error(fc, EXC_VALUE);
        else if (pc != (q + 7) / 8 || pc > STAGE_DEPTH) push_error(fc, EXC_VALUE);
        else begin
          for (int i = 0; i < q; i++) coils[a+i] = stage[i/8][i%8];
          echo4(fc, a, q);
        end
      end
      FC_WR_REGS: begin
        if (!in_range(a, q, NUM_HOLDING)) push_error(fc, EXC_ADDRESS);
        else if (q == 0 || q > MAX_WORDS) push_error(fc, EXC_VALUE);
        else if (pc != 2 * q || pc > STAGE_DEPTH) push_error(fc, EXC_VALUE);
        else begin
          for (int i = 0; i < q; i++) holds[a+i] = {stage[2*i], stage[2*i+1]};
          echo4(fc, a, q);
        end
      end
      default: push_error(fc, EXC_FUNCTION);
    endcase
  endtask

  task automatic predict_item(input req_item_t it);
    case (it.kind)
      KIND_HEADER: begin
        pend_vld = 0;
        stage_cnt = 0;
        if ((it.fc == FC_WR_COILS || it.fc == FC_WR_REGS) && it.pc != 0) begin
          pend_vld = 1;
          pend_fc = it.fc;
          pend_addr = it.addr;
          pend_qv = it.qv;
          pend_pc = it.pc;
        end else serve_request(it.fc, it.addr, it.qv, it.pc);
      end
      KIND_PAYLOAD: if (pend_vld) begin
        stage[stage_cnt] = it.pb;
        stage_cnt = stage_cnt + 8'd1;
        if (stage_cnt == pend_pc) begin
          pend_vld = 0;
          stage_cnt = 0;
          serve_request(pend_fc, pend_addr, pend_qv, pend_pc);
        end
      end
      KIND_SET_DI: if (it.addr < NUM_DISCRETE) discs[it.addr] = (it.qv != 0);
      default: if (it.addr < NUM_INPUT_REGS) iregs[it.addr] = it.qv;
    endcase
  endtask

  // stimulus builders
  function automatic req_item_t mk(kind_t k, int fc, int a, int q, int pc, int pb);
    return '{k, 8'(fc), 16'(a), 16'(q), 8'(pc), 8'(pb)};
  endfunction

  task automatic add_write_multi(input int fc, input int a, input int q, input int pc);
    add_req(mk(KIND_HEADER, fc, a, q, pc, 0));
    for (int i = 0; i < pc; i++)
      add_req(mk(KIND_PAYLOAD, $urandom, $urandom, $urandom, $urandom,
                 $urandom_range(0, 255)));
  endtask

  task automatic add_random;
    int r, fc, a, q, pc;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      fc = $urandom_range(0, 1) ? FC_WR_COILS : FC_WR_REGS;
      q = (fc == FC_WR_COILS) ? $urandom_range(1, 64) : $urandom_range(1, 16);
      a = $urandom_range(0, (fc == FC_WR_COILS ? NUM_COILS : NUM_HOLDING) - q);
      pc = (fc == FC_WR_COILS) ? (q + 7) / 8 : 2 * q;
      if ($urandom_range(0, 9) == 0) pc = $urandom_range(1, 20);
      if ($urandom_range(0, 19) == 0) a = $urandom;
      add_write_multi(fc, a, q, pc);
    end else if (r < 55) begin
      fc = $urandom_range(1, 6);
      q = (fc <= 2) ? $urandom_range(1, 40) : $urandom_range(1, 10);
      a = $urandom_range(0, (fc == 1 || fc == 5) ? NUM_COILS - q :
                            (fc == 2) ? NUM_DISCRETE - q : NUM_HOLDING - q);
      if (fc == 5) q = $urandom_range(0, 1) ? COIL_ON : COIL_OFF;
      if (fc == 6) q = $urandom;
      if ($urandom_range(0, 9) == 0) a = $urandom;
      if ($urandom_range(0, 9) == 0) q = $urandom;
      add_req(mk(KIND_HEADER, fc, a, q, $urandom_range(0, 255), 0));
    end else if (r < 75) begin
      a = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, NUM_DISCRETE - 1);
      add_req(mk(KIND_SET_DI, $urandom, a, $urandom_range(0, 1) ?
                 $urandom : 0, $urandom, $urandom));
    end else if (r < 92) begin
      a = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, NUM_INPUT_REGS - 1);
      add_req(mk(KIND_SET_IR, $urandom, a, $urandom, $urandom, $urandom));
    end else if (r < 96) begin
      add_req(mk(KIND_HEADER, $urandom, $urandom, $urandom, $urandom, 0));
    end else begin
      add_req(mk(KIND_PAYLOAD, $urandom, $urandom, $urandom, $urandom, $urandom));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_item(pending_reqs.pop_front());
      end
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (!(in_ch.valid && !in_ch.ready) && !quiet
                   && $urandom_range(0, 9) == 0 && pending_reqs.size() > 0) begin
        src_gap <= $urandom_range(1, 12);
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_ch.valid <= 1'b1;
        {in_ch.kind, in_ch.fcode, in_ch.start_address, in_ch.qty_value,
         in_ch.payload_count, in_ch.payload_byte} <= pending_reqs[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_item_t got, exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.echo_function, exc_t'(out_ch.exception_code), out_ch.payload_beat,
                out_ch.beat_bytes, out_ch.last_beat};
        if (expected_rsps.size() == 0) report($sformatf("unexpected result %p", got));
        else begin
          exp_r = expected_rsps.pop_front();
          if (got.fc !== exp_r.fc) report($sformatf("fc %h exp %h", got.fc, exp_r.fc));
          if (got.exc !== exp_r.exc) report($sformatf("exc %0d exp %0d", got.exc, exp_r.exc));
          if (got.beat !== exp_r.beat)
            report($sformatf("beat %h exp %h", got.beat, exp_r.beat));
          if (got.nbytes !== exp_r.nbytes)
            report($sformatf("bytes %0d exp %0d", got.nbytes, exp_r.nbytes));
          if (got.last !== exp_r.last) report($sformatf("last %b exp %b", got.last, exp_r.last));
        end
      end
      if (hold_sink) out_ch.ready <= 1'b0;
      else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        snk_gap <= $urandom_range(1, 12);
        out_ch.ready <= 1'b0;
      end else out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic drain;
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_HEADER;
    in_ch.fcode = '0;
    in_ch.start_address = '0;
    in_ch.qty_value = '0;
    in_ch.payload_count = '0;
    in_ch.payload_byte = '0;
    out_ch.ready = 1'b0;
    foreach (coils[i]) coils[i] = 0;
    foreach (discs[i]) discs[i] = 0;
    foreach (holds[i]) holds[i] = '0;
    foreach (iregs[i]) iregs[i] = '0;
    foreach (stage[i]) stage[i] = '0;
    pend_vld = 0;
    stage_cnt = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    add_req(mk(KIND_SET_DI, 0, NUM_DISCRETE - 1, 16'hFFFF, 0, 0));
    add_req(mk(KIND_SET_DI, 0, 16'hFFFF, 1, 0, 0));
    add_req(mk(KIND_SET_IR, 0, NUM_INPUT_REGS - 1, 16'hA5C3, 0, 0));
    add_req(mk(KIND_SET_IR, 0, 16'hFFFF, 16'h1234, 0, 0));
    add_req(mk(KIND_HEADER, FC_RD_DISC, NUM_DISCRETE - 8, 8, 0, 0));
    add_req(mk(KIND_HEADER, FC_RD_INREG, NUM_INPUT_REGS - 2, 2, 0, 0));
    add_req(mk(KIND_HEADER, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 0));
    add_req(mk(KIND_HEADER, FC_RD_COILS, 0, 2001, 0, 0));
    add_req(mk(KIND_HEADER, FC_RD_COILS, 0, 0, 0, 0));
    add_req(mk(KIND_HEADER, FC_RD_HOLD, 0, 126, 0, 0));
    add_req(mk(KIND_HEADER, FC_RD_HOLD, NUM_HOLDING, 1, 0, 0));
    add_req(mk(KIND_HEADER, FC_WR_COIL, 3, 16'h1234, 0, 0));
    add_req(mk(KIND_HEADER, FC_WR_COIL, NUM_COILS - 1, COIL_ON, 7, 0));
    add_req(mk(KIND_HEADER, FC_WR_REG, NUM_HOLDING - 1, 16'hFFFF, 0, 0));
    add_req(mk(KIND_HEADER, FC_WR_COILS, 0, 9, 0, 0));
    add_req(mk(KIND_PAYLOAD, 0, 0, 0, 0, 8'hFF));
    add_write_multi(FC_WR_COILS, 0, 9, 3);
    add_write_multi(FC_WR_REGS, 0, 2, 2);
    add_req(mk(KIND_HEADER, FC_WR_REGS, 0, 2, 4, 0));
    add_req(mk(KIND_PAYLOAD, 0, 0, 0, 0, 8'h5A));
    add_req(mk(KIND_SET_IR, 0, 1, 16'h0F0F, 0, 0));
    add_write_multi(FC_WR_REGS, NUM_HOLDING - 3, 3, 6);
    add_req(mk(KIND_HEADER, FC_RD_HOLD, NUM_HOLDING - 125, 125, 0, 0));
    add_req(mk(KIND_HEADER, FC_RD_COILS, 0, 2000, 0, 0));
    drain();

    // receiver holds off while the sender keeps offering
    hold_sink = 1;
    for (int i = 0; i < 12; i++)
      add_req(mk(KIND_HEADER, FC_RD_HOLD, 0, 20, 0, 0));
    repeat (600) @(posedge clk);
    hold_sink = 0;
    drain();

    add_write_multi(FC_WR_COILS, 0, 200, 25);
    add_req(mk(KIND_HEADER, FC_RD_COILS, 0, 2000, 0, 0));

    for (int i = 0; i < 95; i++) begin
      if (i == 50) begin
        drain();
        repeat (50) @(posedge clk);
      end
      if (i == 80) quiet = 1;
      add_random();
      while (pending_reqs.size() > 40) @(posedge clk);
    end
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/mbsrm_pkg.sv
rtl/mbsrm_if.sv
rtl/mbsrm_front.sv
rtl/mbsrm_fifo.sv
rtl/mbsrm_back.sv
rtl/modbus_server_register_map_unit.sv
rtl/mbsrm_checker.sv
verif/mbsrm_tb_if.sv
verif/tb_modbus_server_register_map_unit.sv
